// ===== hdl/set_assoc_writeback_cache_lfu_assert.svh =====
// Assertion macros for the set-associative write-back cache checker.
`ifndef SET_ASSOC_WRITEBACK_CACHE_LFU_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LFU_ASSERT_SVH

// same-cycle implication
`define SAWBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAWBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sawbc_pkg.sv =====
// Types, sizes and helper functions for the set-associative write-back cache.
package sawbc_pkg;

	localparam int WAYS        = 4;
	localparam int SETS        = 16;
	localparam int BLOCK_WORDS = 4;
	localparam int ADDR_BITS   = 16;
	localparam int COUNT_BITS  = 16;

	localparam int OFF_BITS  = $clog2(BLOCK_WORDS);
	localparam int SET_BITS  = $clog2(SETS);
	localparam int TAG_BITS  = ADDR_BITS - SET_BITS - OFF_BITS;
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_FIELDS = 4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [OFF_BITS-1:0]   off_t;
	typedef logic [SET_BITS-1:0]   set_t;
	typedef logic [TAG_BITS-1:0]   tag_t;
	typedef logic [WAY_BITS-1:0]   way_idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BLOCK_WORDS-1:0][31:0] words_t;

	typedef struct packed {
		logic               opcode;
		logic [15:0]        word_address;
		logic signed [31:0] store_value;
		logic signed [31:0] fill_word_0;
		logic signed [31:0] fill_word_1;
		logic signed [31:0] fill_word_2;
		logic signed [31:0] fill_word_3;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic               writeback;
		logic [15:0]        writeback_address;
		logic signed [31:0] victim_word_0;
		logic signed [31:0] victim_word_1;
		logic signed [31:0] victim_word_2;
		logic signed [31:0] victim_word_3;
	} rsp_t;

	typedef struct packed {
		logic   dirty;
		tag_t   tag;
		count_t count;
		words_t words;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;
	typedef logic [WAYS-1:0] vld_t;

	function automatic addr_t req_addr(req_t r);
		return ADDR_BITS'(r.word_address);
	endfunction

	function automatic set_t req_set(req_t r);
		addr_t a;
		a = req_addr(r);
		return a[OFF_BITS +: SET_BITS];
	endfunction

	function automatic words_t fill_block(req_t r);
		words_t b;
		b = '0;
		for (int j = 0; j < BLOCK_WORDS; j++) begin
			case (j)
				0:       b[j] = r.fill_word_0;
				1:       b[j] = r.fill_word_1;
				2:       b[j] = r.fill_word_2;
				3:       b[j] = r.fill_word_3;
				default: b[j] = '0;
			endcase
		end
		return b;
	endfunction

	function automatic logic [31:0] word_at(words_t b, int j);
		logic [31:0] v;
		v = '0;
		for (int k = 0; k < BLOCK_WORDS; k++) begin
			if (k == j) begin
				v = b[k];
			end
		end
		return v;
	endfunction

endpackage

// ===== hdl/sawbc_store.sv =====
// Line store: per-set row memory with registered read, and per-line valid flops.
module sawbc_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  sawbc_pkg::set_t   rd_set,
	output sawbc_pkg::row_t   rd_row,
	input  logic              wr_en,
	input  sawbc_pkg::set_t   wr_set,
	input  sawbc_pkg::row_t   wr_row,
	input  sawbc_pkg::vld_t   wr_vld,
	input  sawbc_pkg::set_t   vld_set,
	output sawbc_pkg::vld_t   vld_row
);

	sawbc_pkg::row_t mem [sawbc_pkg::SETS];
	sawbc_pkg::vld_t vld_q [sawbc_pkg::SETS];
	sawbc_pkg::row_t rd_row_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < sawbc_pkg::SETS; s++) begin
				vld_q[s] <= '0;
			end
		end else if (wr_en) begin
			vld_q[wr_set] <= wr_vld;
		end
	end

	assign rd_row  = rd_row_q;
	assign vld_row = vld_q[vld_set];

endmodule

// ===== hdl/sawbc_lookup.sv =====
// Tag compare, LFU victim choice, line update and result build for one access.
module sawbc_lookup (
	input  sawbc_pkg::req_t req,
	input  sawbc_pkg::row_t row,
	input  sawbc_pkg::vld_t vld,
	output sawbc_pkg::row_t new_row,
	output sawbc_pkg::vld_t new_vld,
	output sawbc_pkg::rsp_t rsp
);

	sawbc_pkg::addr_t    addr;
	sawbc_pkg::off_t     off;
	sawbc_pkg::set_t     set_idx;
	sawbc_pkg::tag_t     tag;
	logic                found;
	sawbc_pkg::way_idx_t hit_way;
	sawbc_pkg::way_idx_t vic;
	sawbc_pkg::count_t   lowest;
	sawbc_pkg::count_t   cnt [sawbc_pkg::WAYS];
	logic                vic_dirty;
	sawbc_pkg::addr_t    wb_addr;
	logic                is_wr;

	assign addr    = sawbc_pkg::req_addr(req);
	assign off     = addr[sawbc_pkg::OFF_BITS-1:0];
	assign set_idx = addr[sawbc_pkg::OFF_BITS +: sawbc_pkg::SET_BITS];
	assign tag     = addr[sawbc_pkg::ADDR_BITS-1 -: sawbc_pkg::TAG_BITS];
	assign is_wr   = (req.opcode == sawbc_pkg::OP_WRITE);

	// never-filled lines read as cleared
	always_comb begin
		for (int w = 0; w < sawbc_pkg::WAYS; w++) begin
			cnt[w] = vld[w] ? row[w].count : '0;
		end
	end

	always_comb begin
		found   = 1'b0;
		hit_way = '0;
		for (int w = 0; w < sawbc_pkg::WAYS; w++) begin
			if (!found && vld[w] && row[w].tag == tag) begin
				found   = 1'b1;
				hit_way = sawbc_pkg::WAY_BITS'(w);
			end
		end
	end

	// first way holding the lowest count
	always_comb begin
		vic    = '0;
		lowest = cnt[0];
		for (int w = 1; w < sawbc_pkg::WAYS; w++) begin
			if (cnt[w] < lowest) begin
				lowest = cnt[w];
				vic    = sawbc_pkg::WAY_BITS'(w);
			end
		end
	end

	assign vic_dirty = vld[vic] && row[vic].dirty;
	assign wb_addr   = {row[vic].tag, set_idx, sawbc_pkg::off_t'(0)};

	always_comb begin
		new_row = row;
		new_vld = vld;
		if (found) begin
			if (row[hit_way].count != '1) begin
				new_row[hit_way].count = row[hit_way].count + 1'b1;
			end
			if (is_wr) begin
				new_row[hit_way].dirty      = 1'b1;
				new_row[hit_way].words[off] = req.store_value;
			end
		end else begin
			new_vld[vic]         = 1'b1;
			new_row[vic].dirty   = is_wr;
			new_row[vic].tag     = tag;
			new_row[vic].count   = cnt[vic];
			new_row[vic].words   = sawbc_pkg::fill_block(req);
			if (is_wr) begin
				new_row[vic].words[off] = req.store_value;
			end
		end
	end

	always_comb begin
		rsp     = '0;
		rsp.hit = found;
		if (!found && vic_dirty) begin
			rsp.writeback         = 1'b1;
			rsp.writeback_address = 16'(wb_addr);
			rsp.victim_word_0     = sawbc_pkg::word_at(row[vic].words, 0);
			rsp.victim_word_1     = sawbc_pkg::word_at(row[vic].words, 1);
			rsp.victim_word_2     = sawbc_pkg::word_at(row[vic].words, 2);
			rsp.victim_word_3     = sawbc_pkg::word_at(row[vic].words, 3);
		end
	end

endmodule

// ===== hdl/set_assoc_writeback_cache_lfu.sv =====
// Top level of the set-associative write-back cache with LFU replacement.
//  channel | valid     | stall     | payload  | direction
//  request | req_valid | req_stall | req_data | in
//  result  | rsp_valid | rsp_stall | rsp_data | out
// One access per cycle sustained while the result side does not stall; rsp_valid is
// registered as the access leaves the lookup stage. The accepting edge reads the set
// row from the row memory; the lookup stage then compares, updates and writes the row
// back as the result is registered. Same-set back-to-back accesses take the row just
// written. Reset clears valid bits at once; no clearing pass. A stalled result holds
// the access in the lookup stage, which then stalls the request side.
module set_assoc_writeback_cache_lfu (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sawbc_pkg::req_t  req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sawbc_pkg::rsp_t  rsp_data
);

	logic             valid_s1;
	sawbc_pkg::req_t  req_s1;
	logic             fwd_s1;
	sawbc_pkg::row_t  fwd_row_s1;
	logic             out_valid_q;
	sawbc_pkg::rsp_t  rsp_q;

	logic             advance;
	logic             accept;
	sawbc_pkg::set_t  set_s1;
	sawbc_pkg::row_t  mem_row;
	sawbc_pkg::row_t  cur_row;
	sawbc_pkg::vld_t  cur_vld;
	sawbc_pkg::row_t  new_row;
	sawbc_pkg::vld_t  new_vld;
	sawbc_pkg::rsp_t  rsp_s1;

	assign advance   = valid_s1 && (!out_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign set_s1    = sawbc_pkg::req_set(req_s1);
	assign cur_row   = fwd_s1 ? fwd_row_s1 : mem_row;

	sawbc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_set  (sawbc_pkg::req_set(req_data)),
		.rd_row  (mem_row),
		.wr_en   (advance),
		.wr_set  (set_s1),
		.wr_row  (new_row),
		.wr_vld  (new_vld),
		.vld_set (set_s1),
		.vld_row (cur_vld)
	);

	sawbc_lookup u_lookup (
		.req     (req_s1),
		.row     (cur_row),
		.vld     (cur_vld),
		.new_row (new_row),
		.new_vld (new_vld),
		.rsp     (rsp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= advance && (sawbc_pkg::req_set(req_data) == set_s1);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req_data;
			fwd_row_s1 <= new_row;
		end
		if (advance) begin
			rsp_q <= rsp_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== hdl/sawbc_checker.sv =====
// Port-level checker for the cache, bound to the top level.
`include "set_assoc_writeback_cache_lfu_assert.svh"

module sawbc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input sawbc_pkg::rsp_t rsp_data
);

	`SAWBC_ASSERT_IMP(a_hit_no_wb, rsp_valid, !(rsp_data.hit && rsp_data.writeback), "hit with writeback")

	`SAWBC_ASSERT_IMP(a_clean_zero, rsp_valid && !rsp_data.writeback, rsp_data.writeback_address == 16'd0 && rsp_data.victim_word_0 == 32'sd0 && rsp_data.victim_word_1 == 32'sd0 && rsp_data.victim_word_2 == 32'sd0 && rsp_data.victim_word_3 == 32'sd0, "victim fields set without writeback")

	`SAWBC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

	`SAWBC_ASSERT_NXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid, "accepted transaction produced no result")

endmodule

bind set_assoc_writeback_cache_lfu sawbc_checker u_sawbc_checker (.*);
